/* hdl/packed_array_table_macros.svh */
// assertion helpers for the packed array table
`ifndef PACKED_ARRAY_TABLE_MACROS_SVH
`define PACKED_ARRAY_TABLE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define PAT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define PAT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define PAT_ASSERT_IMPL(name, clk, rst_n, ante, cons)

`define PAT_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/pat_pkg.sv */
package pat_pkg;

    localparam int DATA_W           = 32;
    localparam int MODE_W           = 3;
    localparam int POS_W            = 6;
    localparam int STATUS_W         = 2;
    localparam int INDEX_W          = 6;
    localparam int COUNT_W          = 7;
    localparam int DEFAULT_CAPACITY = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND     = 3'd0,
        MODE_REMOVE_AT  = 3'd1,
        MODE_REMOVE_VAL = 3'd2,
        MODE_FIND       = 3'd3,
        MODE_READ_AT    = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

endpackage

/* hdl/pat_if.sv */
// request channel
interface pat_req_if;
    logic                              valid;
    logic                              ready;
    logic        [pat_pkg::MODE_W-1:0] mode;
    logic signed [pat_pkg::DATA_W-1:0] value;
    logic        [pat_pkg::POS_W-1:0]  position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

// result channel
interface pat_rsp_if;
    logic                                valid;
    logic                                ready;
    logic        [pat_pkg::STATUS_W-1:0] status;
    logic        [pat_pkg::INDEX_W-1:0]  found_index;
    logic signed [pat_pkg::DATA_W-1:0]   read_data;
    logic        [pat_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output status, output found_index, output read_data,
                    output count, input ready);
    modport sink   (input valid, input status, input found_index, input read_data,
                    input count, output ready);
endinterface

/* hdl/pat_store.sv */
// word store, one write port and one registered read port
module pat_store #(
    parameter int DEPTH = pat_pkg::DEFAULT_CAPACITY,
    parameter int AW    = $clog2(pat_pkg::DEFAULT_CAPACITY)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [pat_pkg::DATA_W-1:0]  wdata,
    input  logic [AW-1:0]               raddr,
    output logic [pat_pkg::DATA_W-1:0]  rdata
);

    logic [pat_pkg::DATA_W-1:0] mem [DEPTH];
    logic [pat_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/packed_array_table.sv */
// each request passes through dispatch and finish; read-at adds a read step, find scans the
// live words in order until a hit or the end, remove-at shifts the words after the position
// down one place, and remove-value scans and then shifts on a hit
// throughput: one item at a time, the next one taken only once the block is back in idle
// after the result is offered; a result held downstream stalls the finish step
// reset: live count and control clear at once, store contents stay undefined, no clearing pass
`include "packed_array_table_macros.svh"

module packed_array_table #(
    parameter int CAPACITY = pat_pkg::DEFAULT_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    pat_req_if.sink   req,
    pat_rsp_if.source rsp
);

    // address and count widths follow the capacity
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > pat_pkg::POS_W) ? CW : pat_pkg::POS_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE        = CW'(1);

    // control state
    pat_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;     // next address to read
    logic [CW-1:0]    lag_reg, lag_next;     // address whose data sits on the read port
    logic             pend_reg, pend_next;   // read data valid for lag_reg
    logic             rsp_valid_reg, rsp_valid_next;

    // latched request and working result
    pat_pkg::mode_t               mode_reg, mode_next;
    logic [pat_pkg::DATA_W-1:0]   value_reg, value_next;
    logic [pat_pkg::POS_W-1:0]    pos_reg, pos_next;
    pat_pkg::status_t             status_reg, status_next;
    logic [CW-1:0]                index_reg, index_next;
    logic [pat_pkg::DATA_W-1:0]   data_reg, data_next;

    // output register
    logic [pat_pkg::STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [pat_pkg::INDEX_W-1:0]  rsp_index_reg, rsp_index_next;
    logic [pat_pkg::DATA_W-1:0]   rsp_data_reg, rsp_data_next;
    logic [pat_pkg::COUNT_W-1:0]  rsp_count_reg, rsp_count_next;

    // store port
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [pat_pkg::DATA_W-1:0] mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic [pat_pkg::DATA_W-1:0] mem_rdata;

    // handshake and compare conditions
    logic req_fire;
    logic pos_ok;
    logic is_full;
    logic issue;
    logic hit;
    logic walk_done;
    logic out_free;

    pat_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready = (state_reg == pat_pkg::ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign pos_ok    = PW'(pos_reg) < PW'(count_reg);
    assign is_full   = (count_reg == FULL_COUNT);
    assign issue     = (idx_reg < count_reg);
    assign hit       = pend_reg && (mem_rdata == value_reg);
    assign walk_done = !issue && !pend_reg;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pat_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = pat_pkg::ST_DISPATCH;
                end
            end
            pat_pkg::ST_DISPATCH:
            begin
                case (mode_reg)
                    pat_pkg::MODE_REMOVE_AT:
                        state_next = pos_ok ? pat_pkg::ST_SHIFT : pat_pkg::ST_FINISH;
                    pat_pkg::MODE_READ_AT:
                        state_next = pos_ok ? pat_pkg::ST_READ : pat_pkg::ST_FINISH;
                    pat_pkg::MODE_REMOVE_VAL, pat_pkg::MODE_FIND:
                        state_next = pat_pkg::ST_SCAN;
                    default:
                        state_next = pat_pkg::ST_FINISH;
                endcase
            end
            pat_pkg::ST_READ:
            begin
                state_next = pat_pkg::ST_FINISH;
            end
            pat_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = (mode_reg == pat_pkg::MODE_REMOVE_VAL) ?
                                 pat_pkg::ST_SHIFT : pat_pkg::ST_FINISH;
                end
                else if (walk_done)
                begin
                    state_next = pat_pkg::ST_FINISH;
                end
            end
            pat_pkg::ST_SHIFT:
            begin
                if (walk_done)
                begin
                    state_next = pat_pkg::ST_FINISH;
                end
            end
            pat_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = pat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pat_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        lag_next        = lag_reg;
        pend_next       = pend_reg;
        mode_next       = mode_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        status_next     = status_reg;
        index_next      = index_reg;
        data_next       = data_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_index_next  = rsp_index_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_count_next  = rsp_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = lag_reg[AW-1:0] - AW'(1);
        mem_wdata       = mem_rdata;
        mem_raddr       = idx_reg[AW-1:0];

        // result taken downstream
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            pat_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    mode_next  = pat_pkg::mode_t'(req.mode);
                    value_next = req.value;
                    pos_next   = req.position;
                end
            end
            pat_pkg::ST_DISPATCH:
            begin
                status_next = pat_pkg::STATUS_MISS;
                index_next  = '0;
                data_next   = '0;
                idx_next    = '0;
                pend_next   = 1'b0;
                case (mode_reg)
                    pat_pkg::MODE_APPEND:
                    begin
                        if (is_full)
                        begin
                            status_next = pat_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = count_reg[AW-1:0];
                            mem_wdata   = value_reg;
                            count_next  = count_reg + ONE;
                            status_next = pat_pkg::STATUS_DONE;
                        end
                    end
                    pat_pkg::MODE_REMOVE_AT:
                    begin
                        // shift starts by reading the word after the slot
                        if (pos_ok)
                        begin
                            idx_next    = CW'(pos_reg) + ONE;
                            status_next = pat_pkg::STATUS_DONE;
                        end
                    end
                    pat_pkg::MODE_READ_AT:
                    begin
                        if (pos_ok)
                        begin
                            mem_raddr   = AW'(pos_reg);
                            status_next = pat_pkg::STATUS_DONE;
                        end
                    end
                    default:
                    begin
                        status_next = pat_pkg::STATUS_MISS;
                    end
                endcase
            end
            pat_pkg::ST_READ:
            begin
                data_next = mem_rdata;
            end
            pat_pkg::ST_SCAN:
            begin
                // one read issued and one compare done each cycle
                if (issue)
                begin
                    idx_next  = idx_reg + ONE;
                    lag_next  = idx_reg;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (hit)
                begin
                    index_next  = lag_reg;
                    status_next = pat_pkg::STATUS_DONE;
                    idx_next    = lag_reg + ONE;
                    pend_next   = 1'b0;
                end
            end
            pat_pkg::ST_SHIFT:
            begin
                // word read last cycle moves down one place
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (issue)
                begin
                    idx_next  = idx_reg + ONE;
                    lag_next  = idx_reg;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (walk_done)
                begin
                    count_next = count_reg - ONE;
                end
            end
            pat_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_index_next  = pat_pkg::INDEX_W'(index_reg);
                    rsp_data_next   = data_reg;
                    rsp_count_next  = pat_pkg::COUNT_W'(count_reg);
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pat_pkg::ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        lag_reg        <= lag_next;
        mode_reg       <= mode_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        status_reg     <= status_next;
        index_reg      <= index_next;
        data_reg       <= data_next;
        rsp_status_reg <= rsp_status_next;
        rsp_index_reg  <= rsp_index_next;
        rsp_data_reg   <= rsp_data_next;
        rsp_count_reg  <= rsp_count_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.found_index = rsp_index_reg;
    assign rsp.read_data   = rsp_data_reg;
    assign rsp.count       = rsp_count_reg;

    // live count never passes the capacity
    `PAT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_COUNT)
    // count moves only on a dispatch or at the end of a shift
    `PAT_ASSERT_IMPL(a_count_source, clk, rst_n, count_reg != $past(count_reg), $past(state_reg) == pat_pkg::ST_DISPATCH || $past(state_reg) == pat_pkg::ST_SHIFT)
    // a finished item reaches the output register
    `PAT_ASSERT_NEXT(a_result_loaded, clk, rst_n, state_reg == pat_pkg::ST_FINISH && out_free, rsp.valid)
    // store writes only during append or shift
    `PAT_ASSERT_IMPL(a_write_phase, clk, rst_n, mem_we, state_reg == pat_pkg::ST_SHIFT || (state_reg == pat_pkg::ST_DISPATCH && mode_reg == pat_pkg::MODE_APPEND))

endmodule
